### rtl/assert_macros.svh
// Assertion macros shared by the checksum RTL.
// Each macro builds one labeled concurrent assertion with a clock and a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Same check, written as an implication from a trigger.
`define ASSERT_IMPLY(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error(msg);

`endif

### rtl/dtcrc_pkg.sv
// Shared types, constants and the bytewise CRC-32 update for the checksum block.
// No dependencies; used by dtcrc_core and decimal_text_crc32_checksum.
package dtcrc_pkg;

   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
   localparam logic [7:0]  CHAR_DOT  = 8'h2E;
   localparam logic [7:0]  CHAR_ZERO = 8'h30;

   // One character beat as held in the input register.
   typedef struct packed {
      logic [7:0] text_char;
      logic       number_first;
      logic       message_first;
      logic       message_last;
   } beat_type;

   // Reflected CRC-32 over one byte, eight unrolled shift steps.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_i,
                                            input logic [7:0]  byte_i);
      logic [31:0] c;
      c = crc_i ^ {24'd0, byte_i};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/dtcrc_core.sv
// Running CRC state and character filter: drops '.' and leading '0' of each number.
// Depends on dtcrc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dtcrc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  dtcrc_pkg::beat_type beat,
   output logic [31:0]         checksum
);

   logic [31:0] crc_ff, crc_in;
   logic        lz_ff, lz_in;

   logic [31:0] crc_base, crc_new;
   logic        lz_base, lz_new, kept;

   always_comb begin
      crc_base = beat.message_first ? dtcrc_pkg::CRC_INIT : crc_ff;
      lz_base  = beat.number_first | beat.message_first | lz_ff;
      if (beat.number_first | beat.message_first) begin
         lz_base = 1'b1;
      end else begin
         lz_base = lz_ff;
      end
      // a dot neither keeps a byte nor ends the leading-zero run
      if (beat.text_char != dtcrc_pkg::CHAR_DOT) begin
         lz_new = lz_base & (beat.text_char == dtcrc_pkg::CHAR_ZERO);
         kept   = ~lz_new;
      end else begin
         lz_new = lz_base;
         kept   = 1'b0;
      end
      crc_new  = kept ? dtcrc_pkg::crc_byte(crc_base, beat.text_char) : crc_base;
      checksum = ~crc_new;

      crc_in = crc_ff;
      lz_in  = lz_ff;
      if (step) begin
         if (beat.message_last) begin
            crc_in = dtcrc_pkg::CRC_INIT;
            lz_in  = 1'b1;
         end else begin
            crc_in = crc_new;
            lz_in  = lz_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= dtcrc_pkg::CRC_INIT;
         lz_ff  <= 1'b1;
      end else begin
         crc_ff <= crc_in;
         lz_ff  <= lz_in;
      end
   end

   `ASSERT_CLK(a_restart_after_last, clock, reset, (step && beat.message_last) |=> (crc_ff == dtcrc_pkg::CRC_INIT && lz_ff), "state not restarted after last beat")

endmodule

### rtl/decimal_text_crc32_checksum.sv
// Top level: input register, CRC core and result register for the text checksum.
// Depends on dtcrc_pkg, dtcrc_core and assert_macros.svh.
//
// Usage:
//   req_ channel carries one character per beat with its number and message
//   flags; a beat is taken when req_valid is high and req_stall is low.
//   rsp_ channel returns one 32-bit checksum per message, on the beat flagged
//   message_last; it is taken when rsp_valid is high and rsp_stall is low.
//   Throughput: one character per cycle while req_stall is low; the 8-bit
//   unrolled CRC update and the filter sit between the input register and the
//   core/result registers. A final character passes the input register, then
//   the result register, before rsp_valid rises.
//   Stall: while a result waits, non-final characters keep flowing into the
//   CRC; only a final character waits in the input register, and req_stall
//   rises only then.
//   Reset (synchronous, active high): drops any held beat and result, sets the
//   CRC to all ones and restarts leading-zero skipping.
`include "assert_macros.svh"

module decimal_text_crc32_checksum (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_char,
   input  logic        req_number_first,
   input  logic        req_message_first,
   input  logic        req_message_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_checksum_value
);

   dtcrc_pkg::beat_type beat_ff, beat_in;
   logic                beat_valid_ff, beat_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_checksum_value_ff, rsp_checksum_value_in;

   logic        req_take, out_free, advance;
   logic        last_step, held_last;
   logic [31:0] checksum;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = beat_valid_ff & (~beat_ff.message_last | out_free);
   assign req_stall = beat_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign last_step = advance & beat_ff.message_last;
   assign held_last = beat_valid_ff & beat_ff.message_last & rsp_valid_ff;

   dtcrc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .beat     (beat_ff),
      .checksum (checksum)
   );

   always_comb begin
      beat_in       = beat_ff;
      beat_valid_in = beat_valid_ff & ~advance;
      if (req_take) begin
         beat_in.text_char     = req_text_char;
         beat_in.number_first  = req_number_first;
         beat_in.message_first = req_message_first;
         beat_in.message_last  = req_message_last;
         beat_valid_in         = 1'b1;
      end

      rsp_valid_in          = rsp_valid_ff & rsp_stall;
      rsp_checksum_value_in = rsp_checksum_value_ff;
      if (advance && beat_ff.message_last) begin
         rsp_valid_in          = 1'b1;
         rsp_checksum_value_in = checksum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         beat_valid_ff <= beat_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      beat_ff               <= beat_in;
      rsp_checksum_value_ff <= rsp_checksum_value_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_checksum_value = rsp_checksum_value_ff;

   `ASSERT_IMPLY(a_stall_held_last, clock, reset, req_stall, held_last, "stall without held last")
   `ASSERT_CLK(a_last_result, clock, reset, last_step |=> rsp_valid_ff, "last gave no result")

endmodule
